[rtl/gm3_pkg.sv]
`timescale 1ns / 1ps
package gm3_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SIZE_W = 7;
    localparam int ZSIZE_W = 16;
    localparam int SLICE_W = 2 * SIZE_W;
    localparam int SUM_W = 18;
    localparam int NB_CNT = 5;

    localparam logic [CFG_IDX_W-1:0] REG_X_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Z_SIZE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
    localparam logic [ZSIZE_W-1:0] ZSIZE_RESET = 16'd64;
    localparam logic [SUM_W-1:0] SQRT_BIT_START = 18'h10000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_SQRT,
        ST_OUT
    } state_t;

endpackage

[rtl/gm3_ram.sv]
`timescale 1ns / 1ps
module gm3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/gradient_magnitude_3d_core.sv]
`timescale 1ns / 1ps
// 3D central-difference gradient magnitude over a streamed 8-bit volume.
// Input channel (in_valid/in_ready, voxel): voxels in raster order, x fastest,
// followed by one slice of padding transfers whose value is ignored.
// Output channel (out_valid/out_ready, magnitude, last): one result per
// voxel, floor(isqrt(dx^2+dy^2+dz^2)/2); last marks the final voxel, after
// which the counters restart for the next volume.
// Configuration: cfg_we/cfg_index/cfg_data write x_size, y_size, z_size;
// a write to any of these restarts the stream. Write only while the block is idle.
// Throughput: the first slice of a volume is stored at one transfer per
// cycle. Each later transfer is processed in full before the next is taken:
// the reads (five neighbor reads plus the write-back of the new voxel), the
// squared differences, the bit-serial square root (nine steps and a final
// check), loading the output register and the return to idle to take the
// next transfer.
// The result for voxel k is computed when transfer k+S is taken (S = one slice).
// A result held in the output register does not block the next input
// transfer; a new result waits only if the old one has not been taken.
// Reset clears counters and sets the sizes to 64 each; window contents stay undefined.
module gradient_magnitude_3d_core
    import gm3_pkg::*;
#(
    parameter int MAX_X = 64,
    parameter int MAX_Y = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            voxel,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            magnitude,
    output logic                  last
);

    localparam int DEPTH = 2 * MAX_X * MAX_Y;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    state_t state_reg, state_next;

    logic [SIZE_W-1:0]  x_size_reg, y_size_reg;
    logic [ZSIZE_W-1:0] z_size_reg;
    logic [SIZE_W-1:0]  ex, ey;
    logic [ZSIZE_W-1:0] ez;
    logic [SLICE_W-1:0] slice;

    logic [SLICE_W-1:0] item_count_reg;
    logic [SLICE_W-1:0] off_reg;
    logic [SIZE_W-1:0]  out_x_reg, out_y_reg;
    logic [ZSIZE_W-1:0] out_z_reg;
    logic [2:0]         rcnt_reg;
    logic [7:0]         v_reg;
    logic [7:0]         nb_reg [NB_CNT];
    logic [SUM_W-1:0]   rem_reg, root_reg, bit_reg;
    logic               last_reg;

    logic [SLICE_W:0]   cur_w, other_w;
    logic [AW-1:0]      cur, other, raddr, waddr;
    logic [7:0]         rdata, wdata;
    logic               we;
    logic               fill;
    logic               x_in, y_in, z_in, is_last;
    logic [7:0]         dx, dy, dz;
    logic [SUM_W-1:0]   q;
    logic [SUM_W-1:0]   trial;
    logic               out_free;

    // effective sizes
    always_comb
    begin
        if (x_size_reg == '0)
            ex = SIZE_W'(1);
        else if (int'(x_size_reg) > MAX_X)
            ex = SIZE_W'(MAX_X);
        else
            ex = x_size_reg;
        if (y_size_reg == '0)
            ey = SIZE_W'(1);
        else if (int'(y_size_reg) > MAX_Y)
            ey = SIZE_W'(MAX_Y);
        else
            ey = y_size_reg;
        ez = (z_size_reg == '0) ? ZSIZE_W'(1) : z_size_reg;
    end

    assign slice = SLICE_W'(ex) * SLICE_W'(ey);

    assign cur_w = {1'b0, off_reg} + (out_z_reg[0] ? {1'b0, slice} : '0);
    assign other_w = {1'b0, off_reg} + (out_z_reg[0] ? '0 : {1'b0, slice});
    assign cur = AW'(cur_w);
    assign other = AW'(other_w);

    assign fill = (item_count_reg < slice);
    assign x_in = (out_x_reg != '0) && ((SLICE_W'(out_x_reg) + 1'b1) < SLICE_W'(ex));
    assign y_in = (out_y_reg != '0) && ((SLICE_W'(out_y_reg) + 1'b1) < SLICE_W'(ey));
    assign z_in = (out_z_reg != '0) && ((17'(out_z_reg) + 1'b1) < 17'(ez));
    assign is_last = ((SLICE_W'(out_x_reg) + 1'b1) >= SLICE_W'(ex))
                  && ((SLICE_W'(out_y_reg) + 1'b1) >= SLICE_W'(ey))
                  && ((17'(out_z_reg) + 1'b1) >= 17'(ez));

    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid || out_ready;

    // read address sequence: x+1, x-1, y+1, y-1, other slice
    always_comb
    begin
        unique case (rcnt_reg)
            3'd0:    raddr = cur + AW'(1);
            3'd1:    raddr = cur - AW'(1);
            3'd2:    raddr = cur + AW'(ex);
            3'd3:    raddr = cur - AW'(ex);
            default: raddr = other;
        endcase
    end

    always_comb
    begin
        we = 1'b0;
        waddr = other;
        wdata = v_reg;
        if (state_reg == ST_IDLE && in_valid && fill)
        begin
            we = 1'b1;
            waddr = AW'(item_count_reg);
            wdata = voxel;
        end
        else if (state_reg == ST_READ && rcnt_reg == 3'(NB_CNT))
        begin
            we = 1'b1;
        end
    end

    gm3_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_ring (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign dx = (nb_reg[0] > nb_reg[1]) ? nb_reg[0] - nb_reg[1] : nb_reg[1] - nb_reg[0];
    assign dy = (nb_reg[2] > nb_reg[3]) ? nb_reg[2] - nb_reg[3] : nb_reg[3] - nb_reg[2];
    assign dz = (v_reg > nb_reg[4]) ? v_reg - nb_reg[4] : nb_reg[4] - v_reg;
    assign q = (x_in ? SUM_W'(dx) * SUM_W'(dx) : '0)
             + (y_in ? SUM_W'(dy) * SUM_W'(dy) : '0)
             + (z_in ? SUM_W'(dz) * SUM_W'(dz) : '0);
    assign trial = root_reg + bit_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid && !fill && !cfg_we)
                    state_next = ST_READ;
            ST_READ:
                if (rcnt_reg == 3'(NB_CNT))
                    state_next = ST_CALC;
            ST_CALC:
                state_next = ST_SQRT;
            ST_SQRT:
                if (bit_reg == '0)
                    state_next = ST_OUT;
            ST_OUT:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            x_size_reg <= SIZE_RESET;
            y_size_reg <= SIZE_RESET;
            z_size_reg <= ZSIZE_RESET;
            item_count_reg <= '0;
            off_reg <= '0;
            out_x_reg <= '0;
            out_y_reg <= '0;
            out_z_reg <= '0;
            rcnt_reg <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free)
                out_valid <= 1'b1;
            else if (out_valid && out_ready)
                out_valid <= 1'b0;
            if (cfg_we && cfg_index != REG_SPARE)
            begin
                unique case (cfg_index)
                    REG_X_SIZE: x_size_reg <= cfg_data[SIZE_W-1:0];
                    REG_Y_SIZE: y_size_reg <= cfg_data[SIZE_W-1:0];
                    default:    z_size_reg <= cfg_data;
                endcase
                item_count_reg <= '0;
                off_reg <= '0;
                out_x_reg <= '0;
                out_y_reg <= '0;
                out_z_reg <= '0;
            end
            else
            begin
                if (state_reg == ST_IDLE && in_valid && fill)
                    item_count_reg <= item_count_reg + 1'b1;
                if (state_reg == ST_READ)
                    rcnt_reg <= (rcnt_reg == 3'(NB_CNT)) ? '0 : rcnt_reg + 1'b1;
                if (state_reg == ST_OUT && out_free)
                begin
                    if (is_last)
                    begin
                        item_count_reg <= '0;
                        off_reg <= '0;
                        out_x_reg <= '0;
                        out_y_reg <= '0;
                        out_z_reg <= '0;
                    end
                    else if ((SLICE_W'(out_x_reg) + 1'b1) >= SLICE_W'(ex))
                    begin
                        out_x_reg <= '0;
                        if ((SLICE_W'(out_y_reg) + 1'b1) >= SLICE_W'(ey))
                        begin
                            out_y_reg <= '0;
                            off_reg <= '0;
                            out_z_reg <= out_z_reg + 1'b1;
                        end
                        else
                        begin
                            out_y_reg <= out_y_reg + 1'b1;
                            off_reg <= off_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        out_x_reg <= out_x_reg + 1'b1;
                        off_reg <= off_reg + 1'b1;
                    end
                end
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
            v_reg <= voxel;
        if (state_reg == ST_READ && rcnt_reg != '0)
            nb_reg[rcnt_reg - 3'd1] <= rdata;
        if (state_reg == ST_CALC)
        begin
            rem_reg <= q;
            root_reg <= '0;
            bit_reg <= SQRT_BIT_START;
            last_reg <= is_last;
        end
        if (state_reg == ST_SQRT && bit_reg != '0)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (state_reg == ST_OUT && out_free)
        begin
            magnitude <= root_reg[8:1];
            last <= last_reg;
        end
    end

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ST_IDLE))
        else $error("input taken outside idle");
    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> (root_reg < SUM_W'(512)))
        else $error("square root out of range");
    a_sqrt_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQRT) |-> ($onehot(bit_reg) || bit_reg == '0))
        else $error("square root step bit corrupt");
    a_no_fill_write_late: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ && rcnt_reg != 3'(NB_CNT)) |-> !we)
        else $error("ring written during neighbor reads");
`endif

endmodule

[tb/sv/tb_gradient_magnitude_3d_core.sv]
`timescale 1ns / 1ps
module tb_gradient_magnitude_3d_core;
    import gm3_pkg::*;

    localparam int MAXD = 64;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [7:0] magnitude;
        logic       last;
    } grad_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            voxel;
    logic                  out_valid;
    logic                  out_ready;
    logic [7:0]            magnitude;
    logic                  last;

    gradient_magnitude_3d_core DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .voxel(voxel), .out_valid(out_valid), .out_ready(out_ready),
        .magnitude(magnitude), .last(last)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // predictor state
    logic [7:0]  slice_ring [2*MAXD*MAXD];
    int unsigned fill_count;
    int unsigned px, py, pz;
    logic [6:0]  xs_reg, ys_reg;
    logic [15:0] zs_reg;

    grad_result_t expected_q[$];
    int  error_count;
    int  result_count;
    int  volume_count;
    int  cycle_count;
    bit  hold_off;
    bit  in_gap_on;
    bit  out_gap_on;

    function automatic int unsigned eff_x();
        if (xs_reg == 0) return 1;
        return (xs_reg > MAXD) ? MAXD : xs_reg;
    endfunction

    function automatic int unsigned eff_y();
        if (ys_reg == 0) return 1;
        return (ys_reg > MAXD) ? MAXD : ys_reg;
    endfunction

    function automatic int unsigned sq_abs(int unsigned a, int unsigned b);
        int unsigned d;
        d = (a > b) ? a - b : b - a;
        return d * d;
    endfunction

    function automatic int unsigned floor_sqrt(int unsigned v);
        int unsigned r;
        r = 0;
        while ((r + 1) * (r + 1) <= v)
            r++;
        return r;
    endfunction

    task automatic predict_voxel(input logic [7:0] v);
        int unsigned xs, ys, zs, slice, off, cur, oth, q, mag;
        bit          fin;
        grad_result_t res;
        xs = eff_x();
        ys = eff_y();
        zs = (zs_reg == 0) ? 1 : zs_reg;
        slice = xs * ys;
        if (fill_count < slice) begin
            slice_ring[fill_count] = v;
            fill_count++;
            return;
        end
        off = py * xs + px;
        cur = (pz & 1) * slice + off;
        oth = ((pz + 1) & 1) * slice + off;
        q = 0;
        if (px > 0 && px + 1 < xs)
            q += sq_abs(slice_ring[cur+1], slice_ring[cur-1]);
        if (py > 0 && py + 1 < ys)
            q += sq_abs(slice_ring[cur+xs], slice_ring[cur-xs]);
        if (pz > 0 && pz + 1 < zs)
            q += sq_abs(v, slice_ring[oth]);
        slice_ring[oth] = v;
        mag = floor_sqrt(q) >> 1;
        if (mag > 255)
            mag = 255;
        fin = (px + 1 >= xs) && (py + 1 >= ys) && (pz + 1 >= zs);
        res.magnitude = mag[7:0];
        res.last = fin;
        expected_q = {expected_q, res};
        if (fin) begin
            fill_count = 0;
            px = 0;
            py = 0;
            pz = 0;
        end else begin
            px++;
            if (px >= xs) begin
                px = 0;
                py++;
                if (py >= ys) begin
                    py = 0;
                    pz++;
                end
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_X_SIZE: xs_reg = val[6:0];
            REG_Y_SIZE: ys_reg = val[6:0];
            REG_Z_SIZE: zs_reg = val[15:0];
            default: ;
        endcase
        if (idx != REG_SPARE) begin
            fill_count = 0;
            px = 0;
            py = 0;
            pz = 0;
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic set_volume(input int unsigned x, input int unsigned y, input int unsigned z);
        wait_drained();
        write_reg(REG_X_SIZE, x);
        write_reg(REG_Y_SIZE, y);
        write_reg(REG_Z_SIZE, z);
    endtask

    // called at a falling edge; returns at a falling edge after the transfer,
    // leaving valid high until the next gap or drain
    task automatic send_voxel(input logic [7:0] v);
        int gap;
        gap = 0;
        if (in_gap_on)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        voxel <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_voxel(v);
        @(negedge clk);
    endtask

    task automatic send_volume(input int unsigned x, input int unsigned y,
                               input int unsigned z, input int mode);
        int unsigned n;
        n = x * y * (z + 1);
        for (int unsigned i = 0; i < n; i++) begin
            case (mode)
                0: send_voxel(8'($urandom_range(0, 255)));
                1: send_voxel(((i + (i / x) + (i / (x * y))) & 1) ? 8'hFF : 8'h00);
                default: send_voxel($urandom_range(0, 1) ? 8'hFF : 8'h00);
            endcase
        end
    endtask

    task automatic test_extremes();
        in_gap_on = 1'b0;
        out_gap_on = 1'b0;
        set_volume(3, 3, 3);
        send_volume(3, 3, 3, 1);
        set_volume(1, 1, 1);
        send_volume(1, 1, 1, 0);
        send_volume(1, 1, 1, 0);
        set_volume(0, 0, 0);
        send_volume(1, 1, 1, 0);
        set_volume(2, 1, 4);
        send_volume(2, 1, 4, 2);
    endtask

    task automatic test_oversize();
        // x and y sizes above the maximum clamp to 64
        set_volume(127, 2, 2);
        send_volume(64, 2, 2, 0);
        set_volume(3, 100, 1);
        send_volume(3, 64, 1, 2);
    endtask

    task automatic test_restart_midstream();
        set_volume(4, 4, 4);
        for (int i = 0; i < 37; i++)
            send_voxel(8'($urandom_range(0, 255)));
        wait_drained();
        write_reg(REG_Y_SIZE, 4);
        write_reg(REG_SPARE, 16'hFFFF);
        send_volume(4, 4, 4, 0);
    endtask

    task automatic test_random_volumes();
        int unsigned x, y, z, sent;
        in_gap_on = 1'b1;
        out_gap_on = 1'b1;
        sent = 0;
        while (sent < 700) begin
            x = $urandom_range(1, 8);
            y = $urandom_range(1, 8);
            z = $urandom_range(1, 6);
            set_volume(x, y, z);
            send_volume(x, y, z, $urandom_range(0, 3) == 0 ? 2 : 0);
            sent += x * y * (z + 1);
            if ($urandom_range(0, 2) == 0) begin
                send_volume(x, y, z, 0);
                sent += x * y * (z + 1);
            end
        end
    endtask

    task automatic test_backpressure();
        in_gap_on = 1'b0;
        set_volume(5, 4, 6);
        hold_off = 1'b1;
        send_volume(5, 4, 6, 0);
        wait_drained();
        set_volume(MAXD, MAXD, 65535);
        send_volume(1, 1, 1, 0);
        for (int i = 0; i < 32; i++)
            send_voxel(8'hA5 ^ i[7:0]);
    endtask

    // receiver
    initial
    begin
        int gap, hold;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_off) begin
                hold_off = 1'b0;
                out_ready <= 1'b0;
                hold = 400;
                repeat (hold) @(negedge clk);
            end
            if (out_gap_on && $urandom_range(0, 3) == 0) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // checker
    always @(posedge clk)
    begin
        grad_result_t exp_res;
        if (rst_n && out_valid && out_ready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result magnitude=%0d last=%0b", magnitude, last);
                error_count++;
            end else begin
                exp_res = expected_q.pop_front();
                result_count++;
                if (last)
                    volume_count++;
                if (magnitude !== exp_res.magnitude) begin
                    $error("magnitude: expected %0d, got %0d", exp_res.magnitude, magnitude);
                    error_count++;
                end
                if (last !== exp_res.last) begin
                    $error("last: expected %0b, got %0b", exp_res.last, last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        voxel = '0;
        error_count = 0;
        result_count = 0;
        volume_count = 0;
        cycle_count = 0;
        hold_off = 1'b0;
        in_gap_on = 1'b0;
        out_gap_on = 1'b0;
        xs_reg = SIZE_RESET;
        ys_reg = SIZE_RESET;
        zs_reg = ZSIZE_RESET;
        fill_count = 0;
        px = 0;
        py = 0;
        pz = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_oversize();
        test_restart_midstream();
        test_random_volumes();
        test_backpressure();
        wait_drained();
        repeat (100) @(negedge clk);
        if (expected_q.size() != 0) begin
            $error("%0d results still outstanding", expected_q.size());
            error_count++;
        end

        $display("checked %0d gradient results over %0d complete volumes", result_count,
                 volume_count);
        $display("sizes 0..127 per axis, restarts, random gaps and a long output stall");
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
